### sv/tcw_pkg.sv
package tcw_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELL_COUNT  = ROWS * COLUMNS;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int ROW_SUM_W   = ROW_W + 1;
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int ADDR_W      = $clog2(CELL_COUNT);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_BLANK     = 8'h20;
    localparam logic [7:0] ATTR_RESET   = 8'h07;

    typedef enum logic [2:0] {
        CMD_PUT,
        CMD_NEWLINE,
        CMD_BACKSPACE,
        CMD_CLEAR,
        CMD_READ,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [7:0]       char_code;
        logic [ROW_W-1:0] read_row;
        logic [COL_W-1:0] read_col;
        logic             in_range;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ,
        ST_DONE
    } back_state_t;

endpackage

### sv/tcw_front.sv
module tcw_front import tcw_pkg::*; (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
    input  logic [1:0]          s_tuser,   // op[1:0]
    input  logic                init_busy,
    input  logic                q_full,
    output logic                q_push,
    output cmd_t                q_cmd
);

    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;

    assign char_code = s_tdata[7:0];
    assign read_row  = s_tdata[12:8];
    assign read_col  = s_tdata[19:13];

    assign s_tready = !q_full && !init_busy;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        q_cmd.char_code = char_code;
        q_cmd.read_row  = ROW_W'(read_row);
        q_cmd.read_col  = COL_W'(read_col);
        q_cmd.in_range  = (32'(read_row) < 32'(ROWS)) && (32'(read_col) < 32'(COLUMNS));
        unique case (s_tuser)
            OP_PUT: begin
                if (char_code == CH_NEWLINE) begin
                    q_cmd.kind = CMD_NEWLINE;
                end else if (char_code == CH_BACKSPACE) begin
                    q_cmd.kind = CMD_BACKSPACE;
                end else begin
                    q_cmd.kind = CMD_PUT;
                end
            end
            OP_CLEAR: q_cmd.kind = CMD_CLEAR;
            OP_READ:  q_cmd.kind = CMD_READ;
            default:  q_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

### sv/tcw_queue.sv
module tcw_queue import tcw_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t cmd_in,
    input  logic pop,
    output cmd_t cmd_out,
    output logic cmd_valid,
    output logic full
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd_out   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && cmd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

### sv/tcw_back.sv
module tcw_back import tcw_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          text_color,
    input  logic                cmd_valid,
    input  cmd_t                cmd,
    output logic                cmd_pop,
    output logic                init_busy,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    // Screen rows live in a circular buffer; top_reg is the physical row of screen row 0.
    logic [15:0] screen_mem [CELL_COUNT];
    logic [15:0] rd_data_reg;

    back_state_t         state_reg, state_next;
    logic [ROW_W-1:0]    row_now_reg, row_now_next;
    logic [COL_W-1:0]    col_now_reg, col_now_next;
    logic [ROW_W-1:0]    top_reg, top_next;
    logic [ADDR_W-1:0]   sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0]   sweep_last_reg, sweep_last_next;
    logic [15:0]         sweep_cell_reg, sweep_cell_next;
    logic                sweep_init_reg, sweep_init_next;
    logic [15:0]         res_cell_reg, res_cell_next;
    logic                res_scrolled_reg, res_scrolled_next;
    logic                out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [15:0]         mem_wdata;
    logic                advance;
    logic                row_last, col_last;
    logic [ADDR_W-1:0]   cur_addr, bs_addr, rd_addr, scroll_base, pos_full;

    function automatic logic [ADDR_W-1:0] phys_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] top);
        logic [ROW_SUM_W-1:0] sum;
        sum = {1'b0, row} + {1'b0, top};
        if (sum >= ROW_SUM_W'(ROWS)) begin
            sum = sum - ROW_SUM_W'(ROWS);
        end
        return ADDR_W'(sum[ROW_W-1:0]) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

    assign row_last    = (row_now_reg == ROW_W'(ROWS - 1));
    assign col_last    = (col_now_reg == COL_W'(COLUMNS - 1));
    assign cur_addr    = phys_addr(row_now_reg, col_now_reg, top_reg);
    assign bs_addr     = phys_addr(row_now_reg, col_now_reg - 1'b1, top_reg);
    assign rd_addr     = phys_addr(cmd.read_row, cmd.read_col, top_reg);
    assign scroll_base = ADDR_W'(top_reg) * ADDR_W'(COLUMNS);
    assign pos_full    = ADDR_W'(row_now_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_now_reg);

    assign init_busy = (state_reg == ST_SWEEP) && sweep_init_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb begin
        state_next        = state_reg;
        row_now_next      = row_now_reg;
        col_now_next      = col_now_reg;
        top_next          = top_reg;
        sweep_addr_next   = sweep_addr_reg;
        sweep_last_next   = sweep_last_reg;
        sweep_cell_next   = sweep_cell_reg;
        sweep_init_next   = sweep_init_reg;
        res_cell_next     = res_cell_reg;
        res_scrolled_next = res_scrolled_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_data_next     = out_data_reg;
        cmd_pop           = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = sweep_addr_reg;
        mem_wdata         = sweep_cell_reg;
        mem_re            = 1'b0;
        mem_raddr         = rd_addr;
        advance           = 1'b0;

        unique case (state_reg)
            ST_SWEEP: begin
                mem_we = 1'b1;
                if (sweep_addr_reg == sweep_last_reg) begin
                    state_next      = sweep_init_reg ? ST_IDLE : ST_DONE;
                    sweep_init_next = 1'b0;
                end else begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop           = 1'b1;
                    res_cell_next     = '0;
                    res_scrolled_next = 1'b0;
                    state_next        = ST_DONE;
                    unique case (cmd.kind)
                        CMD_PUT: begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_addr;
                            mem_wdata = {text_color, cmd.char_code};
                            if (col_last) begin
                                col_now_next = '0;
                                advance      = 1'b1;
                            end else begin
                                col_now_next = col_now_reg + 1'b1;
                            end
                        end
                        CMD_NEWLINE: begin
                            col_now_next = '0;
                            advance      = 1'b1;
                        end
                        CMD_BACKSPACE: begin
                            if (col_now_reg != '0) begin
                                col_now_next = col_now_reg - 1'b1;
                                mem_we       = 1'b1;
                                mem_waddr    = bs_addr;
                                mem_wdata    = {text_color, CH_BLANK};
                            end
                        end
                        CMD_CLEAR: begin
                            row_now_next    = '0;
                            col_now_next    = '0;
                            top_next        = '0;
                            sweep_addr_next = '0;
                            sweep_last_next = ADDR_W'(CELL_COUNT - 1);
                            sweep_cell_next = {text_color, CH_BLANK};
                            sweep_init_next = 1'b0;
                            state_next      = ST_SWEEP;
                        end
                        CMD_READ: begin
                            if (cmd.in_range) begin
                                mem_re     = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        default: ;
                    endcase
                    if (advance) begin
                        if (row_last) begin
                            // old top row becomes the new bottom row
                            res_scrolled_next = 1'b1;
                            top_next          = (top_reg == ROW_W'(ROWS - 1)) ?
                                                '0 : top_reg + 1'b1;
                            sweep_addr_next   = scroll_base;
                            sweep_last_next   = scroll_base + ADDR_W'(COLUMNS - 1);
                            sweep_cell_next   = {text_color, CH_BLANK};
                            sweep_init_next   = 1'b0;
                            state_next        = ST_SWEEP;
                        end else begin
                            row_now_next = row_now_reg + 1'b1;
                        end
                    end
                end
            end
            ST_READ: begin
                res_cell_next = rd_data_reg;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {res_scrolled_reg, 11'(pos_full), 7'(col_now_reg),
                                      5'(row_now_reg), res_cell_reg};
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_SWEEP;
            row_now_reg      <= '0;
            col_now_reg      <= '0;
            top_reg          <= '0;
            sweep_addr_reg   <= '0;
            sweep_last_reg   <= ADDR_W'(CELL_COUNT - 1);
            sweep_cell_reg   <= {ATTR_RESET, CH_BLANK};
            sweep_init_reg   <= 1'b1;
            res_scrolled_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            row_now_reg      <= row_now_next;
            col_now_reg      <= col_now_next;
            top_reg          <= top_next;
            sweep_addr_reg   <= sweep_addr_next;
            sweep_last_reg   <= sweep_last_next;
            sweep_cell_reg   <= sweep_cell_next;
            sweep_init_reg   <= sweep_init_next;
            res_scrolled_reg <= res_scrolled_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_cell_reg <= res_cell_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= screen_mem[mem_raddr];
        end
    end

endmodule

### sv/text_console_writer_unit.sv
// Results: put, newline, backspace and unused ops finish in the back end directly; a read
// also waits on the registered screen RAM read; a line scroll blanks COLUMNS (80) cells
// and a clear all ROWS*COLUMNS (2000) cells, one write per cycle, before the result.
// Input: the back end handles one request at a time; a 2-entry queue decouples input.
// Reset: synchronous, active low; a clearing pass then fills all ROWS*COLUMNS (2000)
// cells with 0x0720, one per cycle, with s_tready low; text_color resets to 7.
module text_console_writer_unit import tcw_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
    input  logic [1:0]          s_tuser,   // op[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // cell_value[15:0], cursor_row[20:16],
                                           // cursor_col[27:21], cursor_pos[38:28], scrolled[39]
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [7:0] text_color_reg;
    logic       init_busy;
    logic       q_full, q_push, q_pop, q_valid;
    cmd_t       q_cmd_in, q_cmd_out;

    // single register; every address in the window maps to text_color
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {24'd0, text_color_reg} : {24'd0, text_color_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg <= ATTR_RESET;
        end else if (psel && penable && pwrite && pready) begin
            text_color_reg <= pwdata[7:0];
        end
    end

    tcw_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .init_busy (init_busy),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd_in)
    );

    tcw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .cmd_in    (q_cmd_in),
        .pop       (q_pop),
        .cmd_out   (q_cmd_out),
        .cmd_valid (q_valid),
        .full      (q_full)
    );

    tcw_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .text_color (text_color_reg),
        .cmd_valid  (q_valid),
        .cmd        (q_cmd_out),
        .cmd_pop    (q_pop),
        .init_busy  (init_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import tcw_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam logic [1:0] REG_TEXT_COLOR = 2'd0;
    localparam int         END_WAIT       = 2100;

    typedef struct {
        logic [1:0] op;
        logic [7:0] ch;
        logic [4:0] row;
        logic [6:0] col;
    } console_req_t;

    typedef struct packed {
        logic [15:0] cell_val;
        logic [4:0]  row;
        logic [6:0]  col;
        logic [10:0] pos;
        logic        scrolled;
    } cursor_report_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [1:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [1:0]          paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;

    console_req_t   pending_reqs[$];
    cursor_report_t predicted_reports[$];

    logic [15:0] screen_copy[CELL_COUNT];
    int          cur_row;
    int          cur_col;
    logic [7:0]  text_attr;

    int   mismatch_count = 0;
    int   send_gap       = 0;
    int   recv_gap       = 0;
    logic calm           = 1'b0;
    logic hold_trigger   = 1'b0;
    logic recv_hold      = 1'b0;

    text_console_writer_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    initial begin
        #60ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic advance_row();
        int i;
        cur_row++;
        if (cur_row >= ROWS) begin
            for (i = 0; i < (ROWS - 1) * COLUMNS; i++)
                screen_copy[i] = screen_copy[i + COLUMNS];
            for (i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++)
                screen_copy[i] = {text_attr, CH_BLANK};
            cur_row = ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic cursor_report_t console_apply(console_req_t r);
        cursor_report_t rep;
        int             i;
        int             lin;
        rep = '0;
        if (r.op == OP_PUT) begin
            if (r.ch == CH_NEWLINE) begin
                cur_col = 0;
                rep.scrolled = advance_row();
            end else if (r.ch == CH_BACKSPACE) begin
                if (cur_col > 0) begin
                    cur_col--;
                    screen_copy[cur_row * COLUMNS + cur_col] = {text_attr, CH_BLANK};
                end
            end else begin
                screen_copy[cur_row * COLUMNS + cur_col] = {text_attr, r.ch};
                cur_col++;
                if (cur_col >= COLUMNS) begin
                    cur_col = 0;
                    rep.scrolled = advance_row();
                end
            end
        end else if (r.op == OP_CLEAR) begin
            for (i = 0; i < CELL_COUNT; i++)
                screen_copy[i] = {text_attr, CH_BLANK};
            cur_row = 0;
            cur_col = 0;
        end else if (r.op == OP_READ) begin
            if (r.row < ROWS && r.col < COLUMNS)
                rep.cell_val = screen_copy[r.row * COLUMNS + r.col];
        end
        lin     = cur_row * COLUMNS + cur_col;
        rep.row = cur_row[4:0];
        rep.col = cur_col[6:0];
        rep.pos = lin[10:0];
        return rep;
    endfunction

    function automatic void push_req(logic [1:0] op, logic [7:0] ch, logic [4:0] row,
                                     logic [6:0] col);
        console_req_t r;
        r.op  = op;
        r.ch  = ch;
        r.row = row;
        r.col = col;
        pending_reqs.push_back(r);
    endfunction

    // nl_pct: share of newlines in percent; low values give long lines that wrap
    function automatic void push_random(int nl_pct);
        int pick;
        pick = $urandom_range(0, 999);
        if (pick < 5)
            push_req(OP_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
        else if (pick < 25)
            push_req(OP_UNUSED, 8'($urandom), 5'($urandom), 7'($urandom));
        else if (pick < 175) begin
            if ($urandom_range(0, 6) == 0)
                push_req(OP_READ, 8'($urandom), 5'($urandom), 7'($urandom));
            else
                push_req(OP_READ, 8'($urandom), 5'($urandom_range(0, ROWS - 1)),
                         7'($urandom_range(0, COLUMNS - 1)));
        end else if (pick < 175 + nl_pct * 10)
            push_req(OP_PUT, CH_NEWLINE, 5'($urandom), 7'($urandom));
        else if (pick < 250 + nl_pct * 10)
            push_req(OP_PUT, CH_BACKSPACE, 5'($urandom), 7'($urandom));
        else if (pick < 300 + nl_pct * 10)
            push_req(OP_PUT, 8'($urandom_range(0, 255)), 5'($urandom), 7'($urandom));
        else
            push_req(OP_PUT, 8'($urandom_range(32, 126)), 5'($urandom), 7'($urandom));
    endfunction

    function automatic void note_mismatch(string what, cursor_report_t want,
                                          cursor_report_t got);
        if (mismatch_count < 10)
            $display({"%0t %s: expected cell=%h row=%0d col=%0d pos=%0d scr=%b, ",
                      "got cell=%h row=%0d col=%0d pos=%0d scr=%b"},
                     $realtime, what, want.cell_val, want.row, want.col, want.pos,
                     want.scrolled, got.cell_val, got.row, got.col, got.pos, got.scrolled);
        mismatch_count++;
    endfunction

    task automatic apb_access(logic wr, logic [1:0] addr, logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (!wr && prdata !== data) begin
            if (mismatch_count < 10)
                $display("%0t text_color readback: expected %h, got %h", $realtime, data, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_color(logic [7:0] attr);
        apb_access(1'b1, REG_TEXT_COLOR, {24'd0, attr});
        text_attr = attr;
        apb_access(1'b0, REG_TEXT_COLOR, {24'd0, attr});
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || s_tvalid || predicted_reports.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // request driver
    always @(posedge aclk) begin
        console_req_t r;
        logic         valid_next;
        valid_next = s_tvalid;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                r.op  = s_tuser;
                r.ch  = s_tdata[7:0];
                r.row = s_tdata[12:8];
                r.col = s_tdata[19:13];
                predicted_reports.push_back(console_apply(r));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0 && !calm) begin
                    send_gap--;
                    valid_next = 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    r = pending_reqs.pop_front();
                    s_tdata    <= {4'd0, r.col, r.row, r.ch};
                    s_tuser    <= r.op;
                    valid_next = 1'b1;
                    if ($urandom_range(0, 11) == 0)
                        send_gap = $urandom_range(1, 19);
                end else begin
                    valid_next = 1'b0;
                end
            end
        end
        s_tvalid <= valid_next;
    end

    // result monitor
    always @(posedge aclk) begin
        cursor_report_t got;
        cursor_report_t want;
        logic           ready_next;
        if (aresetn && m_tvalid && m_tready) begin
            got.cell_val = m_tdata[15:0];
            got.row      = m_tdata[20:16];
            got.col      = m_tdata[27:21];
            got.pos      = m_tdata[38:28];
            got.scrolled = m_tdata[39];
            if (predicted_reports.size() == 0) begin
                note_mismatch("unexpected result", '0, got);
            end else begin
                want = predicted_reports.pop_front();
                if (got.cell_val !== want.cell_val || got.row !== want.row ||
                    got.col !== want.col || got.pos !== want.pos ||
                    got.scrolled !== want.scrolled)
                    note_mismatch("result", want, got);
            end
        end
        if (recv_hold) begin
            ready_next = 1'b0;
        end else if (recv_gap > 0 && !calm) begin
            recv_gap--;
            ready_next = 1'b0;
        end else begin
            ready_next = 1'b1;
            if ($urandom_range(0, 11) == 0)
                recv_gap = $urandom_range(1, 19);
        end
        m_tready <= ready_next;
    end

    // long receiver hold so the input queue fills and backs up
    initial begin
        wait (hold_trigger);
        @(posedge aclk);
        recv_hold <= 1'b1;
        repeat (400) @(posedge aclk);
        recv_hold <= 1'b0;
    end

    initial begin
        int i;
        for (i = 0; i < CELL_COUNT; i++)
            screen_copy[i] = {ATTR_RESET, CH_BLANK};
        cur_row   = 0;
        cur_col   = 0;
        text_attr = ATTR_RESET;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        push_req(OP_READ, 8'h00, 5'd0, 7'd0);
        push_req(OP_READ, 8'h00, 5'd24, 7'd79);
        push_req(OP_READ, 8'h00, 5'd25, 7'd0);
        push_req(OP_READ, 8'hFF, 5'd31, 7'd127);
        push_req(OP_READ, 8'h00, 5'd0, 7'd80);
        push_req(OP_PUT, 8'h41, 5'd0, 7'd0);
        push_req(OP_PUT, 8'h00, 5'd0, 7'd0);
        push_req(OP_PUT, 8'hFF, 5'd31, 7'd127);
        push_req(OP_READ, 8'h00, 5'd0, 7'd1);
        push_req(OP_PUT, CH_BACKSPACE, 5'd0, 7'd0);
        push_req(OP_READ, 8'h00, 5'd0, 7'd2);
        push_req(OP_READ, 8'h00, 5'd0, 7'd0);
        push_req(OP_PUT, CH_NEWLINE, 5'd0, 7'd0);
        push_req(OP_PUT, CH_BACKSPACE, 5'd0, 7'd0);
        push_req(OP_PUT, 8'h7E, 5'd0, 7'd0);
        push_req(OP_UNUSED, 8'hFF, 5'd31, 7'd127);
        push_req(OP_READ, 8'h00, 5'd1, 7'd0);
        push_req(OP_CLEAR, 8'h00, 5'd0, 7'd0);
        push_req(OP_READ, 8'h00, 5'd0, 7'd0);
        push_req(OP_READ, 8'h00, 5'd1, 7'd0);
        drain();

        set_color(8'h00);
        for (i = 0; i < 200; i++)
            push_random(25);
        drain();

        set_color(8'hFF);
        for (i = 0; i < 200; i++)
            push_random(1);
        drain();

        set_color(8'($urandom_range(1, 254)));
        hold_trigger = 1'b1;
        for (i = 0; i < 200; i++)
            push_random(10);
        drain();

        set_color(8'h1E);
        calm = 1'b1;
        for (i = 0; i < 200; i++)
            push_random(8);
        drain();

        repeat (END_WAIT) @(posedge aclk);
        if (mismatch_count == 0 && predicted_reports.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
